// ===== design/vld_pkg.sv =====
`default_nettype none

package vld_pkg;

  // Decode phase within one message
  typedef enum logic [2:0] {
    PH_OP    = 3'd0,
    PH_FLAGS = 3'd1,
    PH_LEN   = 3'd2,
    PH_PAY   = 3'd3,
    PH_DISC  = 3'd4
  } phase_t;

  // Classification of each byte
  typedef enum logic [2:0] {
    KIND_OP      = 3'd0,
    KIND_FLAGS   = 3'd1,
    KIND_LEN     = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_DISCARD = 3'd4
  } kind_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_HDR = 3'd1,
    ST_TRUNC_LEN = 3'd2,
    ST_PAST_END  = 3'd3,
    ST_TOO_MANY  = 3'd4,
    ST_TOO_WIDE  = 3'd5
  } status_t;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned OUT_LEN_W   = 32;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned SHIFT_W     = 6;
  localparam logic [CFG_W-1:0] MAX_FIELDS_RESET = 7'd64;

  // One result item
  typedef struct packed {
    kind_t                byte_kind;
    logic [BYTE_W-1:0]    byte_value;
    logic [IDX_W-1:0]     field_index;
    logic [OUT_LEN_W-1:0] field_length;
    logic                 length_done;
    logic [OUT_LEN_W-1:0] payload_offset;
    logic [BYTE_W-1:0]    op_code;
    logic [BYTE_W-1:0]    flag_bits;
    logic                 frame_done;
    status_t              status;
  } result_t;

endpackage

`default_nettype wire

// ===== design/varint_length_deframer.sv =====
`default_nettype none

// Length-prefixed message deframer. Each byte of a message (opcode, flags, then
// fields made of a base-128 little-endian length and that many payload bytes,
// last byte flagged by end_of_frame) yields one result that classifies the byte
// and reports field index, decoded length, payload offset, latched opcode/flags
// and a status code. The block takes one byte per cycle while in_stall is low:
// each byte is decoded by one pass of combinational logic against the frame
// state and lands in a result register backed by one skid entry, and in_stall
// rises only when both result entries are full. After an error the rest of the
// message is reported as discarded; all frame state clears on the end-of-frame
// byte. max_fields may be rewritten whenever no message is in flight.
module varint_length_deframer #(
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned MAX_FIELDS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_frame,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       byte_kind,
  output logic [7:0]       byte_value,
  output logic [5:0]       field_index,
  output logic [31:0]      field_length,
  output logic             length_done,
  output logic [31:0]      payload_offset,
  output logic [7:0]       op_code,
  output logic [7:0]       flag_bits,
  output logic             frame_done,
  output logic [2:0]       status,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  max_fields
);

  localparam int unsigned FC_W  = $clog2(MAX_FIELDS + 1);
  localparam int unsigned CMP_W = (FC_W > vld_pkg::CFG_W) ? FC_W : vld_pkg::CFG_W;

  // Frame state
  vld_pkg::phase_t                phase, phase_next;
  logic [vld_pkg::BYTE_W-1:0]     opcode_reg, opcode_reg_next;
  logic [vld_pkg::BYTE_W-1:0]     flags_reg, flags_reg_next;
  logic [LEN_BITS-1:0]            length_accum, length_accum_next;
  logic [vld_pkg::SHIFT_W-1:0]    shift_count, shift_count_next;
  logic [LEN_BITS-1:0]            payload_left, payload_left_next;
  logic [FC_W-1:0]                field_count, field_count_next;
  vld_pkg::status_t               error_code, error_code_next;
  logic [vld_pkg::CFG_W-1:0]      max_fields_reg;

  // Result register and skid entry
  vld_pkg::result_t               res_next;
  vld_pkg::result_t               res_q;
  logic                           res_valid;
  vld_pkg::result_t               skid_q;
  logic                           skid_valid;

  logic                           in_accept;
  logic                           out_fire;

  // Length digit decode helpers
  logic [vld_pkg::DIGIT_W-1:0]    digit;
  logic [CMP_W-1:0]               field_limit;
  logic                           too_many;
  logic                           shift_beyond;
  logic [6:0]                     bits_left;
  logic                           too_wide;
  logic [6:0]                     shift_sum;
  logic [vld_pkg::SHIFT_W-1:0]    shift_sat;
  logic [LEN_BITS-1:0]            accum_base;
  logic [LEN_BITS-1:0]            accum_new;
  logic [FC_W-1:0]                count_new;
  logic [LEN_BITS-1:0]            pay_dec;
  logic [LEN_BITS-1:0]            pay_offset;
  logic [63:0]                    accum_new_ext;
  logic [63:0]                    accum_ext;
  logic [63:0]                    offset_ext;
  logic [15:0]                    idx_new_ext;
  logic [15:0]                    idx_cur_ext;

  assign in_accept = in_valid && !in_stall;
  assign out_fire  = res_valid && !out_stall;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields_reg <= vld_pkg::MAX_FIELDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_fields_reg <= max_fields;
    end
  end

  // Field limit and width checks
  assign digit        = in_byte[vld_pkg::DIGIT_W-1:0];
  assign field_limit  = (CMP_W'(max_fields_reg) < CMP_W'(MAX_FIELDS)) ?
                        CMP_W'(max_fields_reg) : CMP_W'(MAX_FIELDS);
  assign too_many     = (shift_count == '0) && (CMP_W'(field_count) >= field_limit);
  assign shift_beyond = ({1'b0, shift_count} >= 7'(LEN_BITS));
  assign bits_left    = 7'(LEN_BITS) - {1'b0, shift_count};
  assign too_wide     = shift_beyond ? (digit != '0) :
                        ((bits_left < 7'(vld_pkg::DIGIT_W)) &&
                         ((digit >> bits_left[2:0]) != '0));
  assign shift_sum    = {1'b0, shift_count} + 7'(vld_pkg::DIGIT_W);
  assign shift_sat    = shift_sum[6] ? {vld_pkg::SHIFT_W{1'b1}} : shift_sum[5:0];
  assign accum_base   = (shift_count == '0) ? '0 : length_accum;
  assign accum_new    = accum_base | (LEN_BITS'(digit) << shift_count);
  assign count_new    = (shift_count == '0) ? (field_count + FC_W'(1)) : field_count;
  assign pay_dec      = payload_left - LEN_BITS'(1);
  assign pay_offset   = length_accum - payload_left;
  assign accum_new_ext = 64'(accum_new);
  assign accum_ext     = 64'(length_accum);
  assign offset_ext    = 64'(pay_offset);
  assign idx_new_ext   = 16'(count_new - FC_W'(1));
  assign idx_cur_ext   = 16'(field_count - FC_W'(1));

  // Per-byte decode
  always_comb begin
    phase_next        = phase;
    opcode_reg_next   = opcode_reg;
    flags_reg_next    = flags_reg;
    length_accum_next = length_accum;
    shift_count_next  = shift_count;
    payload_left_next = payload_left;
    field_count_next  = field_count;
    error_code_next   = error_code;
    res_next            = '0;
    res_next.byte_kind  = vld_pkg::KIND_DISCARD;
    res_next.byte_value = in_byte;
    res_next.frame_done = end_of_frame;
    res_next.status     = vld_pkg::ST_OK;

    unique case (phase)
      vld_pkg::PH_OP: begin
        opcode_reg_next    = in_byte;
        res_next.byte_kind = vld_pkg::KIND_OP;
        phase_next         = vld_pkg::PH_FLAGS;
        if (end_of_frame) begin
          res_next.status = vld_pkg::ST_SHORT_HDR;
        end
      end
      vld_pkg::PH_FLAGS: begin
        flags_reg_next     = in_byte;
        res_next.byte_kind = vld_pkg::KIND_FLAGS;
        phase_next         = vld_pkg::PH_LEN;
        length_accum_next  = '0;
        shift_count_next   = '0;
      end
      vld_pkg::PH_LEN: begin
        if (too_many) begin
          error_code_next = vld_pkg::ST_TOO_MANY;
          res_next.status = vld_pkg::ST_TOO_MANY;
          phase_next      = vld_pkg::PH_DISC;
        end else if (too_wide) begin
          error_code_next = vld_pkg::ST_TOO_WIDE;
          res_next.status = vld_pkg::ST_TOO_WIDE;
          phase_next      = vld_pkg::PH_DISC;
        end else begin
          field_count_next      = count_new;
          length_accum_next     = accum_new;
          shift_count_next      = shift_sat;
          res_next.byte_kind    = vld_pkg::KIND_LEN;
          res_next.field_index  = idx_new_ext[vld_pkg::IDX_W-1:0];
          res_next.field_length = accum_new_ext[vld_pkg::OUT_LEN_W-1:0];
          if (in_byte[vld_pkg::BYTE_W-1]) begin
            if (end_of_frame) begin
              res_next.status = vld_pkg::ST_TRUNC_LEN;
            end
          end else begin
            res_next.length_done = 1'b1;
            shift_count_next     = '0;
            if (accum_new != '0) begin
              payload_left_next = accum_new;
              phase_next        = vld_pkg::PH_PAY;
              if (end_of_frame) begin
                res_next.status = vld_pkg::ST_PAST_END;
              end
            end
          end
        end
      end
      vld_pkg::PH_PAY: begin
        res_next.byte_kind      = vld_pkg::KIND_PAYLOAD;
        res_next.field_index    = idx_cur_ext[vld_pkg::IDX_W-1:0];
        res_next.field_length   = accum_ext[vld_pkg::OUT_LEN_W-1:0];
        res_next.payload_offset = offset_ext[vld_pkg::OUT_LEN_W-1:0];
        payload_left_next       = pay_dec;
        if (pay_dec == '0) begin
          phase_next       = vld_pkg::PH_LEN;
          shift_count_next = '0;
        end else if (end_of_frame) begin
          res_next.status = vld_pkg::ST_PAST_END;
        end
      end
      default: begin
        res_next.byte_kind = vld_pkg::KIND_DISCARD;
        res_next.status    = error_code;
      end
    endcase

    res_next.op_code   = opcode_reg_next;
    res_next.flag_bits = flags_reg_next;
  end

  // Frame state update; end of frame returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (in_accept && end_of_frame)) begin
      phase        <= vld_pkg::PH_OP;
      opcode_reg   <= '0;
      flags_reg    <= '0;
      length_accum <= '0;
      shift_count  <= '0;
      payload_left <= '0;
      field_count  <= '0;
      error_code   <= vld_pkg::ST_OK;
    end else if (in_accept) begin
      phase        <= phase_next;
      opcode_reg   <= opcode_reg_next;
      flags_reg    <= flags_reg_next;
      length_accum <= length_accum_next;
      shift_count  <= shift_count_next;
      payload_left <= payload_left_next;
      field_count  <= field_count_next;
      error_code   <= error_code_next;
    end
  end

  // Result register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || out_fire) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the result entries
  always_ff @(posedge clk) begin
    if (!res_valid || out_fire) begin
      res_q <= skid_valid ? skid_q : res_next;
    end
    if (res_valid && !out_fire && in_accept) begin
      skid_q <= res_next;
    end
  end

  assign out_valid      = res_valid;
  assign byte_kind      = res_q.byte_kind;
  assign byte_value     = res_q.byte_value;
  assign field_index    = res_q.field_index;
  assign field_length   = res_q.field_length;
  assign length_done    = res_q.length_done;
  assign payload_offset = res_q.payload_offset;
  assign op_code        = res_q.op_code;
  assign flag_bits      = res_q.flag_bits;
  assign frame_done     = res_q.frame_done;
  assign status         = res_q.status;

`ifndef SYNTHESIS
  // skid entry only fills behind a held result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry valid without result valid");

  // an accepted end-of-frame byte restarts decoding at the opcode
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && end_of_frame) |=> (phase == vld_pkg::PH_OP))
    else $error("phase not back to opcode after end of frame");

  // discard phase always carries one of the two discard error codes
  a_disc_code: assert property (@(posedge clk) disable iff (rst)
    (phase == vld_pkg::PH_DISC) |->
      ((error_code == vld_pkg::ST_TOO_MANY) || (error_code == vld_pkg::ST_TOO_WIDE)))
    else $error("discard phase without discard error code");

  // payload phase never holds an exhausted count
  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == vld_pkg::PH_PAY) |-> (payload_left != '0))
    else $error("payload phase with zero bytes left");
`endif

endmodule

`default_nettype wire
